// ----- rtl/assert_macros.svh -----
// assertion macros included by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled in reset
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- rtl/mte_pkg.sv -----
// shared widths, constants and types of the move time estimator
`timescale 1ns / 1ps
package mte_pkg;
  localparam int P_W       = 32;
  localparam int S_W       = 13;
  localparam int A_W       = 8;
  localparam int K_W       = 9;
  localparam int PER_W     = 16;
  localparam int SET_W     = 16;
  localparam int T_W       = 32;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_D_W   = 16;

  localparam int N_W       = 54;
  localparam int D_W       = 34;
  localparam int SQ_T_W    = 20;
  localparam int SQ_R_W    = 56;
  localparam int DIV_CELLS = N_W;
  localparam int SQ_CELLS  = SQ_T_W;

  localparam logic [PER_W-1:0] PER_RESET    = 16'd3200;
  localparam logic [SET_W-1:0] SETTLE_RESET = 16'd250;

  localparam logic [CFG_IDX_W-1:0] CFG_PPR    = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SETTLE = 4'd1;

  localparam logic [15:0]  C_LVL0 = 16'd60000;
  localparam logic [20:0]  C_DIST = 21'd1200000;
  localparam logic [13:0]  C_NEED = 14'd12000;
  localparam logic [4:0]   C_TRAP = 5'd20;
  localparam logic [K_W-1:0] K_BASE = 9'd256;

  typedef enum logic [1:0] {
    MODE_ZERO,
    MODE_NOPER,
    MODE_DIV,
    MODE_SQRT
  } mte_mode_t;

  typedef struct packed {
    mte_mode_t         mode;
    logic [SQ_T_W:0]   t;
  } mte_meta_t;
endpackage

// ----- rtl/mte_in_if.sv -----
// move request channel
`timescale 1ns / 1ps
interface mte_in_if;
  import mte_pkg::*;
  logic             valid;
  logic             ready;
  logic [P_W-1:0]   pulse_count;
  logic [S_W-1:0]   speed_rpm;
  logic [A_W-1:0]   accel_level;
  modport source (output valid, pulse_count, speed_rpm, accel_level, input ready);
  modport sink   (input valid, pulse_count, speed_rpm, accel_level, output ready);
endinterface

// ----- rtl/mte_out_if.sv -----
// move time result channel
`timescale 1ns / 1ps
interface mte_out_if;
  import mte_pkg::*;
  logic           valid;
  logic           ready;
  logic [T_W-1:0] time_ms;
  logic           saturated;
  modport source (output valid, time_ms, saturated, input ready);
  modport sink   (input valid, time_ms, saturated, output ready);
endinterface

// ----- rtl/mte_cfg_if.sv -----
// register write channel
`timescale 1ns / 1ps
interface mte_cfg_if;
  import mte_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_D_W-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/mte_div_cell.sv -----
// one restoring division cell, one quotient bit per cell
`timescale 1ns / 1ps
module mte_div_cell (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    valid_i,
  input  logic [mte_pkg::D_W-1:0] rem_i,
  input  logic [mte_pkg::D_W-1:0] div_i,
  input  logic [mte_pkg::N_W-1:0] num_i,
  input  logic [mte_pkg::N_W-1:0] quo_i,
  input  mte_pkg::mte_meta_t      meta_i,
  output logic                    valid_o,
  output logic [mte_pkg::D_W-1:0] rem_o,
  output logic [mte_pkg::D_W-1:0] div_o,
  output logic [mte_pkg::N_W-1:0] num_o,
  output logic [mte_pkg::N_W-1:0] quo_o,
  output mte_pkg::mte_meta_t      meta_o
);
  import mte_pkg::*;

  logic [D_W:0]   trial;
  logic [D_W:0]   diff;
  logic           ge;
  logic           valid_r;
  logic [D_W-1:0] rem_r;
  logic [D_W-1:0] div_r;
  logic [N_W-1:0] num_r;
  logic [N_W-1:0] quo_r;
  mte_meta_t      meta_r;

  assign trial = {rem_i, num_i[N_W-1]};
  assign ge    = trial >= {1'b0, div_i};
  assign diff  = trial - {1'b0, div_i};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= ge ? diff[D_W-1:0] : trial[D_W-1:0];
      div_r  <= div_i;
      num_r  <= {num_i[N_W-2:0], 1'b0};
      quo_r  <= {quo_i[N_W-2:0], ge};
      meta_r <= meta_i;
    end
  end

  assign valid_o = valid_r;
  assign rem_o   = rem_r;
  assign div_o   = div_r;
  assign num_o   = num_r;
  assign quo_o   = quo_r;
  assign meta_o  = meta_r;
endmodule

// ----- rtl/mte_sqrt_cell.sv -----
// one square root cell, one root bit per cell
`timescale 1ns / 1ps
module mte_sqrt_cell (
  input  logic                       clk,
  input  logic                       en,
  input  logic [mte_pkg::SQ_R_W-1:0] rem_i,
  input  logic [mte_pkg::SQ_R_W-1:0] acc_i,
  input  logic [mte_pkg::SQ_R_W-1:0] unit_i,
  input  logic [mte_pkg::SQ_T_W-1:0] root_i,
  output logic [mte_pkg::SQ_R_W-1:0] rem_o,
  output logic [mte_pkg::SQ_R_W-1:0] acc_o,
  output logic [mte_pkg::SQ_R_W-1:0] unit_o,
  output logic [mte_pkg::SQ_T_W-1:0] root_o
);
  import mte_pkg::*;

  logic [SQ_R_W:0]   sub;
  logic              take;
  logic [SQ_R_W-1:0] rem_r;
  logic [SQ_R_W-1:0] acc_r;
  logic [SQ_R_W-1:0] unit_r;
  logic [SQ_T_W-1:0] root_r;

  // accept the bit while (root with bit)^2 * per stays below the need
  assign sub  = {1'b0, acc_i} + {1'b0, unit_i};
  assign take = {1'b0, rem_i} > sub;

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= take ? (rem_i - sub[SQ_R_W-1:0]) : rem_i;
      acc_r  <= (acc_i >> 1) + (take ? unit_i : '0);
      unit_r <= unit_i >> 2;
      root_r <= {root_i[SQ_T_W-2:0], take};
    end
  end

  assign rem_o  = rem_r;
  assign acc_o  = acc_r;
  assign unit_o = unit_r;
  assign root_o = root_r;
endmodule

// ----- rtl/trapezoid_motion_time_estimator.sv -----
// top level: move time estimator with front multipliers and cell chains
// One move is accepted per clock while in_ch.ready is high; a result passes the input register,
// 2 multiplier stages, 54 division cells and one output register; the 54-cell division chain
// sets the latency, the sqrt chain of 20 cells runs beside it. A two-entry output buffer keeps
// in_ch.ready off any combinational path from out_ch.ready; in_ch.ready drops only while the skid
// entry holds a result. Registers may be written only while no move is in flight; there is no
// start-up sweep.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module trapezoid_motion_time_estimator (
  input logic      clk,
  input logic      rst_n,
  mte_in_if.sink   in_ch,
  mte_out_if.source out_ch,
  mte_cfg_if.sink  cfg_ch
);
  import mte_pkg::*;

  logic [PER_W-1:0] per_r;
  logic [SET_W-1:0] settle_r;

  logic pipe_en;
  logic skid_valid_r;
  logic out_valid_r;

  logic           s0_valid_r;
  logic [P_W-1:0] s0_p_r;
  logic [S_W-1:0] s0_s_r;
  logic [A_W-1:0] s0_a_r;

  logic [K_W-1:0] k;

  logic             s1_valid_r;
  logic             s1_zero_r;
  logic             s1_noper_r;
  logic             s1_lvl0_r;
  logic [28:0]      s1_ps_r;
  logic [21:0]      s1_sk_r;
  logic [47:0]      s1_n0_r;
  logic [52:0]      s1_dist_r;
  logic [40:0]      s1_pk_r;
  logic [PER_W-1:0] s1_per_r;

  logic             s2_valid_r;
  logic             s2_zero_r;
  logic             s2_noper_r;
  logic             s2_lvl0_r;
  logic [28:0]      s2_ps_r;
  logic [50:0]      s2_ramp_r;
  logic [54:0]      s2_need_r;
  logic [D_W-1:0]   s2_dtrap_r;
  logic [47:0]      s2_n0_r;
  logic [52:0]      s2_dist_r;
  logic [PER_W-1:0] s2_per_r;

  mte_meta_t        meta0;

  logic             dv_valid [DIV_CELLS+1];
  logic [D_W-1:0]   dv_rem   [DIV_CELLS+1];
  logic [D_W-1:0]   dv_div   [DIV_CELLS+1];
  logic [N_W-1:0]   dv_num   [DIV_CELLS+1];
  logic [N_W-1:0]   dv_quo   [DIV_CELLS+1];
  mte_meta_t        dv_meta  [DIV_CELLS+1];

  logic [SQ_R_W-1:0] sq_rem  [SQ_CELLS+1];
  logic [SQ_R_W-1:0] sq_acc  [SQ_CELLS+1];
  logic [SQ_R_W-1:0] sq_unit [SQ_CELLS+1];
  logic [SQ_T_W-1:0] sq_root [SQ_CELLS+1];

  logic [N_W:0]   t_full;
  logic [N_W+1:0] total;
  logic [T_W-1:0] res_time;
  logic           res_sat;
  logic           last_valid;

  logic [T_W-1:0] out_time_r;
  logic           out_sat_r;
  logic [T_W-1:0] skid_time_r;
  logic           skid_sat_r;

  // configuration registers
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      per_r    <= PER_RESET;
      settle_r <= SETTLE_RESET;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_PPR:    per_r    <= cfg_ch.data;
        CFG_SETTLE: settle_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  assign pipe_en     = !skid_valid_r;
  assign in_ch.ready = pipe_en;

  // front stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else if (pipe_en) begin
      s0_valid_r <= in_ch.valid;
      s1_valid_r <= s0_valid_r;
      s2_valid_r <= s1_valid_r;
    end
  end

  assign k = K_BASE - K_W'(s0_a_r);

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s0_p_r     <= in_ch.pulse_count;
      s0_s_r     <= in_ch.speed_rpm;
      s0_a_r     <= in_ch.accel_level;

      s1_zero_r  <= (s0_p_r == '0) || (s0_s_r == '0);
      s1_noper_r <= per_r == '0;
      s1_lvl0_r  <= s0_a_r == '0;
      s1_ps_r    <= 29'(per_r) * 29'(s0_s_r);
      s1_sk_r    <= 22'(s0_s_r) * 22'(k);
      s1_n0_r    <= 48'(C_LVL0) * 48'(s0_p_r);
      s1_dist_r  <= 53'(C_DIST) * 53'(s0_p_r);
      s1_pk_r    <= 41'(s0_p_r) * 41'(k);
      s1_per_r   <= per_r;

      s2_zero_r  <= s1_zero_r;
      s2_noper_r <= s1_noper_r;
      s2_lvl0_r  <= s1_lvl0_r;
      s2_ps_r    <= s1_ps_r;
      s2_ramp_r  <= 51'(s1_ps_r) * 51'(s1_sk_r);
      s2_need_r  <= 55'(C_NEED) * 55'(s1_pk_r);
      s2_dtrap_r <= D_W'(C_TRAP) * D_W'(s1_ps_r);
      s2_n0_r    <= s1_n0_r;
      s2_dist_r  <= s1_dist_r;
      s2_per_r   <= s1_per_r;
    end
  end

  // chain inputs
  always_comb begin
    meta0.t = '0;
    priority if (s2_zero_r) begin
      meta0.mode = MODE_ZERO;
    end else if (s2_noper_r) begin
      meta0.mode = MODE_NOPER;
    end else if (s2_lvl0_r || (s2_dist_r >= s2_ramp_r)) begin
      meta0.mode = MODE_DIV;
    end else begin
      meta0.mode = MODE_SQRT;
    end
  end

  assign dv_valid[0] = s2_valid_r;
  assign dv_rem[0]   = '0;
  assign dv_quo[0]   = '0;
  assign dv_meta[0]  = meta0;
  assign dv_num[0]   = s2_lvl0_r ? N_W'(s2_n0_r) : (N_W'(s2_dist_r) + N_W'(s2_ramp_r));
  assign dv_div[0]   = s2_lvl0_r ? D_W'(s2_ps_r) : s2_dtrap_r;

  assign sq_rem[0]  = SQ_R_W'(s2_need_r);
  assign sq_acc[0]  = '0;
  assign sq_unit[0] = SQ_R_W'(s2_per_r) << (2 * (SQ_CELLS - 1));
  assign sq_root[0] = '0;

  for (genvar i = 0; i < SQ_CELLS; i++) begin : g_sq
    mte_sqrt_cell u_cell (
      .clk    (clk),
      .en     (pipe_en),
      .rem_i  (sq_rem[i]),
      .acc_i  (sq_acc[i]),
      .unit_i (sq_unit[i]),
      .root_i (sq_root[i]),
      .rem_o  (sq_rem[i+1]),
      .acc_o  (sq_acc[i+1]),
      .unit_o (sq_unit[i+1]),
      .root_o (sq_root[i+1])
    );
  end

  for (genvar i = 0; i < DIV_CELLS; i++) begin : g_div
    mte_meta_t m_in;
    if (i == SQ_CELLS) begin : g_tap
      always_comb begin
        m_in   = dv_meta[i];
        m_in.t = (SQ_T_W+1)'(sq_root[SQ_CELLS]) + (SQ_T_W+1)'(1);
      end
    end else begin : g_pass
      assign m_in = dv_meta[i];
    end

    mte_div_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (pipe_en),
      .valid_i (dv_valid[i]),
      .rem_i   (dv_rem[i]),
      .div_i   (dv_div[i]),
      .num_i   (dv_num[i]),
      .quo_i   (dv_quo[i]),
      .meta_i  (m_in),
      .valid_o (dv_valid[i+1]),
      .rem_o   (dv_rem[i+1]),
      .div_o   (dv_div[i+1]),
      .num_o   (dv_num[i+1]),
      .quo_o   (dv_quo[i+1]),
      .meta_o  (dv_meta[i+1])
    );
  end

  // result
  assign last_valid = dv_valid[DIV_CELLS];

  always_comb begin
    unique case (dv_meta[DIV_CELLS].mode)
      MODE_SQRT: t_full = (N_W+1)'(dv_meta[DIV_CELLS].t);
      default:   t_full = (N_W+1)'(dv_quo[DIV_CELLS])
                          + (N_W+1)'(dv_rem[DIV_CELLS] != '0);
    endcase
    total = (N_W+2)'(t_full) + (N_W+2)'(settle_r);
  end

  always_comb begin
    unique case (dv_meta[DIV_CELLS].mode)
      MODE_ZERO: begin
        res_time = '0;
        res_sat  = 1'b0;
      end
      MODE_NOPER: begin
        res_time = '1;
        res_sat  = 1'b1;
      end
      default: begin
        res_sat  = |total[N_W+1:T_W];
        res_time = res_sat ? '1 : total[T_W-1:0];
      end
    endcase
  end

  // output register and skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_valid_r && !out_ch.ready) begin
      if (pipe_en && last_valid) begin
        skid_valid_r <= 1'b1;
      end
    end else if (skid_valid_r) begin
      out_valid_r  <= 1'b1;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r <= last_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid_r && !out_ch.ready) begin
      if (pipe_en) begin
        skid_time_r <= res_time;
        skid_sat_r  <= res_sat;
      end
    end else if (skid_valid_r) begin
      out_time_r <= skid_time_r;
      out_sat_r  <= skid_sat_r;
    end else begin
      out_time_r <= res_time;
      out_sat_r  <= res_sat;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.time_ms   = out_time_r;
  assign out_ch.saturated = out_sat_r;

  `ASSERT_SAME(a_skid_behind_out, clk, rst_n, skid_valid_r, out_valid_r)
  `ASSERT_NEXT(a_skid_holds, clk, rst_n, skid_valid_r && !out_ch.ready, skid_valid_r && out_valid_r)
  `ASSERT_SAME(a_sat_max, clk, rst_n, out_valid_r && out_sat_r, out_time_r == '1)
endmodule
